// ===== hw/rtl/scfl_pkg.sv =====
package scfl_pkg;

    localparam int NUM_CLASSES_C = 36;
    localparam int MAX_SIZE_C    = 1024;
    localparam int CHUNK_BYTES_C = 4096;
    localparam int POOL_CHUNKS_C = 32;
    localparam int ADDR_W        = 17;
    localparam int LINK_W        = 15;
    localparam int IDX_W         = 14;
    localparam int CLS_W         = 6;
    localparam int BSZ_W         = 11;

    localparam logic [LINK_W-1:0] LINK_NULL = 15'h4000;

    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_OVER    = 2'd2;
    localparam logic [1:0] ST_EXHAUST = 2'd3;

    typedef struct packed {
        logic        command;
        logic [15:0] req_size;
        logic [16:0] free_address;
    } t_req;

    typedef struct packed {
        logic [16:0] block_address;
        logic [1:0]  status;
    } t_rsp;

    // classified request passed from front to back
    typedef struct packed {
        logic             command;
        logic             special;
        logic [1:0]       status;
        logic [CLS_W-1:0] cls;
        logic [IDX_W-1:0] gran;
    } t_job;

    function automatic logic [BSZ_W-1:0] block_size(input logic [CLS_W-1:0] c);
        logic [BSZ_W-1:0] r;
        begin
            case (c)
                6'd0:  r = 11'd8;    6'd1:  r = 11'd16;   6'd2:  r = 11'd32;
                6'd3:  r = 11'd48;   6'd4:  r = 11'd64;   6'd5:  r = 11'd96;
                6'd6:  r = 11'd128;  6'd7:  r = 11'd144;  6'd8:  r = 11'd160;
                6'd9:  r = 11'd176;  6'd10: r = 11'd192;  6'd11: r = 11'd224;
                6'd12: r = 11'd256;  6'd13: r = 11'd288;  6'd14: r = 11'd320;
                6'd15: r = 11'd352;  6'd16: r = 11'd384;  6'd17: r = 11'd416;
                6'd18: r = 11'd480;  6'd19: r = 11'd512;
                default: begin
                    if (c >= 6'd35) r = 11'd1024;
                    else r = BSZ_W'(11'd544 + 11'(c - 6'd20) * 11'd32);
                end
            endcase
            return r;
        end
    endfunction

    // smallest class holding size (1..1024)
    function automatic logic [CLS_W-1:0] size_class(input logic [10:0] s);
        logic [CLS_W-1:0] r;
        begin
            if (s <= 11'd8) r = 6'd0;
            else if (s <= 11'd16) r = 6'd1;
            else if (s <= 11'd64) r = CLS_W'((s + 11'd15) >> 4) - 6'd0 + 6'd0;
            else r = 6'd0;
            if (s > 11'd16 && s <= 11'd64) begin
                // 32,48,64 -> 2,3,4
                r = CLS_W'(((s + 11'd15) >> 4)) ;
            end
            if (s > 11'd64 && s <= 11'd96) r = 6'd5;
            else if (s > 11'd96 && s <= 11'd128) r = 6'd6;
            else if (s > 11'd128 && s <= 11'd256) begin
                if (s <= 11'd192) r = CLS_W'(((s + 11'd15) >> 4) - 11'd2);
                else if (s <= 11'd224) r = 6'd11;
                else r = 6'd12;
            end else if (s > 11'd256 && s <= 11'd416) begin
                r = CLS_W'(((s + 11'd31) >> 5) + 11'd4);
            end else if (s > 11'd416 && s <= 11'd480) r = 6'd18;
            else if (s > 11'd480) r = CLS_W'(((s + 11'd31) >> 5) + 11'd3);
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/scfl_ram.sv =====
module scfl_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/scfl_front.sv =====
module scfl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  scfl_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output scfl_pkg::t_job o_job
);
    import scfl_pkg::*;

    localparam int QD = 2;

    t_job       r_q [QD];
    logic [1:0] r_cnt;
    logic       r_rd;
    t_job       w_job;
    logic       w_push, w_pop;

    always_comb begin
        w_job         = '0;
        w_job.command = i_req.command;
        w_job.gran    = i_req.free_address[3 +: IDX_W];
        w_job.cls     = size_class(i_req.req_size[10:0]);
        if (i_req.req_size == 16'd0) begin
            w_job.special = 1'b1;
            w_job.status  = ST_ZERO;
        end else if (i_req.req_size > 16'(MAX_SIZE_C)) begin
            w_job.special = 1'b1;
            w_job.status  = ST_OVER;
        end
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
        end else begin
            if (w_push) r_q[r_rd ^ r_cnt[0] ^ (w_pop ? 1'b0 : 1'b0)] <= w_job;
            if (w_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// ===== hw/rtl/scfl_back.sv =====
module scfl_back #(
    parameter int CHUNK_BYTES = scfl_pkg::CHUNK_BYTES_C,
    parameter int POOL_CHUNKS = scfl_pkg::POOL_CHUNKS_C
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  scfl_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output scfl_pkg::t_rsp o_rsp
);
    import scfl_pkg::*;

    localparam int CU_W = $clog2(POOL_CHUNKS + 1);
    localparam int CB_W = $clog2(CHUNK_BYTES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_CARV = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]               r_st;
    logic [NUM_CLASSES_C-1:0] r_hv;
    logic [CU_W-1:0]          r_used;
    t_job                     r_job;
    logic [IDX_W-1:0]         r_g;
    logic [ADDR_W-1:0]        r_cur, r_base;
    logic [CB_W-1:0]          r_rem;
    logic [BSZ_W-1:0]         r_bsz;
    logic                     r_more;
    logic                     r_ov;
    t_rsp                     r_rsp;

    logic                     w_we;
    logic [IDX_W-1:0]         w_waddr, w_raddr;
    logic [LINK_W-1:0]        w_wdata, w_rdata;
    logic                     w_hwe;
    logic [LINK_W-1:0]        w_hwdata, w_hrdata;
    logic [LINK_W-1:0]        w_head;
    logic [ADDR_W-1:0]        w_next;
    logic                     w_take;

    scfl_ram #(.WIDTH(LINK_W), .DEPTH(1 << IDX_W)) u_link (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // class heads, read at the edge that takes the request
    scfl_ram #(.WIDTH(LINK_W), .DEPTH(NUM_CLASSES_C)) u_heads (
        .i_clk(i_clk), .i_we(w_hwe), .i_waddr(r_job.cls), .i_wdata(w_hwdata),
        .i_raddr(i_job.cls), .o_rdata(w_hrdata)
    );

    assign w_take  = (r_st == S_IDLE) && (!r_ov || i_ready);
    assign w_head  = r_hv[r_job.cls] ? w_hrdata : LINK_NULL;
    assign w_raddr = w_head[IDX_W-1:0];
    assign w_next  = r_cur + ADDR_W'(r_bsz);
    assign o_ready = w_take;
    assign o_valid = r_ov;
    assign o_rsp   = r_rsp;

    always_comb begin
        w_we     = 1'b0;
        w_waddr  = r_job.gran;
        w_wdata  = w_head;
        w_hwe    = 1'b0;
        w_hwdata = {1'b0, r_job.gran};
        if (r_st == S_READ && !r_job.special && r_job.command == CMD_FREE) begin
            w_we  = 1'b1;
            w_hwe = 1'b1;
        end
        if (r_st == S_CARV) begin
            w_we    = 1'b1;
            w_waddr = r_cur[3 +: IDX_W];
            w_wdata = r_more ? {1'b0, w_next[3 +: IDX_W]} : LINK_NULL;
            if (r_cur == r_base) begin
                w_hwe    = 1'b1;
                w_hwdata = r_more ? {1'b0, w_next[3 +: IDX_W]} : LINK_NULL;
            end
        end
        if (r_st == S_OUT) begin
            w_hwe    = 1'b1;
            w_hwdata = w_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_used <= '0;
            r_ov   <= 1'b0;
            r_hv   <= '0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            if (w_hwe) r_hv[r_job.cls] <= 1'b1;
            case (r_st)
                S_IDLE: begin
                    if (i_valid && w_take) begin
                        r_job <= i_job;
                        r_st  <= S_READ;
                    end
                end
                S_READ: begin
                    r_rsp.block_address <= '0;
                    r_rsp.status        <= r_job.status;
                    r_st                <= S_IDLE;
                    if (r_job.special) begin
                        r_ov <= 1'b1;
                    end else if (r_job.command == CMD_FREE) begin
                        r_rsp.status <= ST_DONE;
                        r_ov         <= 1'b1;
                    end else if (!w_head[IDX_W]) begin
                        r_g  <= w_head[IDX_W-1:0];
                        r_st <= S_OUT;
                    end else if (r_used >= CU_W'(POOL_CHUNKS)) begin
                        r_rsp.status <= ST_EXHAUST;
                        r_ov         <= 1'b1;
                    end else begin
                        r_bsz  <= block_size(r_job.cls);
                        r_base <= ADDR_W'(32'(r_used) * 32'(CHUNK_BYTES));
                        r_cur  <= ADDR_W'(32'(r_used) * 32'(CHUNK_BYTES));
                        r_rem  <= CB_W'(CHUNK_BYTES);
                        r_st   <= S_DIV;
                    end
                end
                S_DIV: begin
                    // remaining bytes after this block decide whether another follows
                    r_rem  <= r_rem - CB_W'(r_bsz);
                    r_more <= (r_rem - CB_W'(r_bsz)) >= CB_W'(r_bsz);
                    r_st   <= S_CARV;
                end
                S_CARV: begin
                    if (r_more) begin
                        r_cur <= w_next;
                        r_st  <= S_DIV;
                    end else begin
                        r_rsp.block_address <= r_base;
                        r_rsp.status        <= ST_DONE;
                        r_used              <= r_used + CU_W'(1);
                        r_ov                <= 1'b1;
                        r_st                <= S_IDLE;
                    end
                end
                S_OUT: begin
                    r_rsp.block_address <= {r_g, 3'b000};
                    r_rsp.status        <= ST_DONE;
                    r_ov                <= 1'b1;
                    r_st                <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/size_class_free_list_allocator_core.sv =====
// Size-class free-list block allocator.
// Request channel (i_req_valid/o_req_ready, i_req): allocate or free with a
// byte size. Response channel (o_rsp_valid/i_rsp_ready, o_rsp): one response
// per request, block address and status.
// A front stage classifies the size and queues the request (two entries);
// the back stage does one list operation at a time from the class heads and
// the next-link memory (one read port, registered read).
// Special sizes and frees are answered from the read state, pops also pass the
// output state; an allocate that carves a new chunk steps the divide and carve
// states once per block carved (CHUNK_BYTES / block size blocks).
// The back stage takes a new request only when idle and no response is left waiting.
// Reset empties all class lists and the chunk count; the link memory is not
// cleared and needs none.
// A stalled response holds the back stage; the queue then fills and
// o_req_ready drops.
module size_class_free_list_allocator_core #(
    parameter int CHUNK_BYTES = scfl_pkg::CHUNK_BYTES_C,
    parameter int POOL_CHUNKS = scfl_pkg::POOL_CHUNKS_C
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  scfl_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output scfl_pkg::t_rsp o_rsp
);
    import scfl_pkg::*;

    t_job w_job;
    logic w_jv, w_jr;

    scfl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_req_valid), .o_ready(o_req_ready), .i_req(i_req),
        .o_valid(w_jv), .i_ready(w_jr), .o_job(w_job)
    );

    scfl_back #(.CHUNK_BYTES(CHUNK_BYTES), .POOL_CHUNKS(POOL_CHUNKS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_jv), .o_ready(w_jr), .i_job(w_job),
        .o_valid(o_rsp_valid), .i_ready(i_rsp_ready), .o_rsp(o_rsp)
    );
endmodule
